>>> rtl/core/msq_pkg.sv
// Package for the marching squares cell: widths, edge codes, case tables.
// No dependencies.
`timescale 1ns / 1ps
package msq_pkg;
  localparam int unsigned GridDimDefault    = 1024;
  localparam int unsigned LevelCountDefault = 64;
  localparam int unsigned CoordW = 10;
  localparam int unsigned HeightW = 16;
  localparam int unsigned TagW = 6;
  localparam int unsigned PointW = 19;
  localparam int unsigned FracW = 9;
  localparam int unsigned QuoW = 26;

  typedef enum logic [1:0] {
    EdgeBottom = 2'd0,
    EdgeRight  = 2'd1,
    EdgeTop    = 2'd2,
    EdgeLeft   = 2'd3
  } edge_e;

  typedef struct packed {
    logic [1:0] n;
    edge_e      e0;
    edge_e      e1;
    edge_e      e2;
    edge_e      e3;
  } segs_t;

  function automatic segs_t case_segs(input logic [3:0] idx, input logic alt);
    segs_t s;
    s = '{n: 2'd1, e0: EdgeBottom, e1: EdgeBottom, e2: EdgeBottom, e3: EdgeBottom};
    case (idx)
      4'd0, 4'd15: s.n = 2'd0;
      4'd1:  begin s.e0 = EdgeBottom; s.e1 = EdgeLeft;   end
      4'd2:  begin s.e0 = EdgeRight;  s.e1 = EdgeBottom; end
      4'd3:  begin s.e0 = EdgeRight;  s.e1 = EdgeLeft;   end
      4'd4:  begin s.e0 = EdgeTop;    s.e1 = EdgeRight;  end
      4'd5: begin
        s.n = 2'd2;
        if (alt) begin
          s.e0 = EdgeBottom; s.e1 = EdgeRight; s.e2 = EdgeTop; s.e3 = EdgeLeft;
        end else begin
          s.e0 = EdgeBottom; s.e1 = EdgeLeft; s.e2 = EdgeTop; s.e3 = EdgeRight;
        end
      end
      4'd6:  begin s.e0 = EdgeTop;    s.e1 = EdgeBottom; end
      4'd7:  begin s.e0 = EdgeTop;    s.e1 = EdgeLeft;   end
      4'd8:  begin s.e0 = EdgeLeft;   s.e1 = EdgeTop;    end
      4'd9:  begin s.e0 = EdgeBottom; s.e1 = EdgeTop;    end
      4'd10: begin
        s.n = 2'd2;
        if (alt) begin
          s.e0 = EdgeLeft; s.e1 = EdgeBottom; s.e2 = EdgeRight; s.e3 = EdgeTop;
        end else begin
          s.e0 = EdgeRight; s.e1 = EdgeBottom; s.e2 = EdgeLeft; s.e3 = EdgeTop;
        end
      end
      4'd11: begin s.e0 = EdgeRight;  s.e1 = EdgeTop;    end
      4'd12: begin s.e0 = EdgeLeft;   s.e1 = EdgeRight;  end
      4'd13: begin s.e0 = EdgeBottom; s.e1 = EdgeRight;  end
      4'd14: begin s.e0 = EdgeLeft;   s.e1 = EdgeBottom; end
      default: s.n = 2'd0;
    endcase
    return s;
  endfunction
endpackage

>>> rtl/core/msq_div.sv
// Pipelined restoring divider for one edge crossing fraction, one quotient bit per stage.
// Widths come from its parameters; it does not use msq_pkg.
`timescale 1ns / 1ps
module msq_div #(
  parameter int unsigned NumW = 25,
  parameter int unsigned DenW = 17,
  parameter int unsigned QW   = 9,
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_o,
  output logic [TagW-1:0] tag_o
);
  // numerator must stay below den*2^QW; its bits above QW seed the remainder
  localparam int unsigned RemW = DenW + 1;
  logic [QW:0]           v_q;
  logic [NumW-1:0]       n_q [QW+1];
  logic [DenW-1:0]       d_q [QW+1];
  logic [RemW-1:0]       r_q [QW+1];
  logic [QW-1:0]         qb_q [QW+1];
  logic [TagW-1:0]       t_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[QW-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    n_q[0] <= num_i; d_q[0] <= den_i; r_q[0] <= RemW'(num_i >> QW); qb_q[0] <= '0;
    t_q[0] <= tag_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RemW-1:0] sh;
    logic            ge;
    assign sh = {r_q[s][RemW-2:0], n_q[s][QW-1-s]};
    assign ge = sh >= {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      n_q[s+1]  <= n_q[s];
      d_q[s+1]  <= d_q[s];
      t_q[s+1]  <= t_q[s];
      r_q[s+1]  <= ge ? sh - {1'b0, d_q[s]} : sh;
      qb_q[s+1] <= {qb_q[s][QW-2:0], ge};
    end
  end

  assign valid_o = v_q[QW];
  assign quo_o   = qb_q[QW];
  assign tag_o   = t_q[QW];
endmodule

>>> rtl/core/msq_emit.sv
// Output sequencer: buffers finished cells and emits up to two segments each.
// Uses msq_pkg types.
`timescale 1ns / 1ps
module msq_emit #(
  parameter int unsigned Depth = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [msq_pkg::TagW-1:0]          tag_i,
  input  msq_pkg::segs_t                    segs_i,
  input  logic [4*msq_pkg::PointW*2-1:0]    pts_i,
  output logic                              full_o,
  output logic                              seg_valid_o,
  output logic [msq_pkg::TagW-1:0]          tag_o,
  output logic [msq_pkg::PointW-1:0]        from_x_o,
  output logic [msq_pkg::PointW-1:0]        from_y_o,
  output logic [msq_pkg::PointW-1:0]        to_x_o,
  output logic [msq_pkg::PointW-1:0]        to_y_o,
  output logic [1:0]                        from_edge_o,
  output logic [1:0]                        to_edge_o,
  output logic                              last_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned PW = msq_pkg::PointW;
  typedef struct packed {
    logic [msq_pkg::TagW-1:0] tag;
    msq_pkg::segs_t           segs;
    logic [8*PW-1:0]          pts;
  } ent_t;

  ent_t          mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          k_q;
  logic          pop, lastseg, push;
  ent_t          h;
  logic [1:0]    fe, te;

  assign push = valid_i && (segs_i.n != 2'd0);
  assign h    = mem_q[rp_q];
  assign lastseg = (h.segs.n == 2'd1) || k_q;
  assign pop  = (cnt_q != '0) && lastseg;
  // points packed per edge: {x,y} for edges 3..0
  assign fe = k_q ? h.segs.e2 : h.segs.e0;
  assign te = k_q ? h.segs.e3 : h.segs.e1;
  assign full_o = cnt_q >= (AW+1)'(Depth - 12);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; k_q <= 1'b0; seg_valid_o <= 1'b0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
      if (cnt_q != '0) k_q <= !lastseg;
      seg_valid_o <= cnt_q != '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{tag: tag_i, segs: segs_i, pts: pts_i};
    tag_o       <= h.tag;
    from_x_o    <= h.pts[fe*2*PW+PW +: PW];
    from_y_o    <= h.pts[fe*2*PW +: PW];
    to_x_o      <= h.pts[te*2*PW+PW +: PW];
    to_y_o      <= h.pts[te*2*PW +: PW];
    from_edge_o <= fe;
    to_edge_o   <= te;
    last_o      <= lastseg;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (AW+1)'(Depth))
    else $error("emit queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) k_q |-> h.segs.n == 2'd2)
    else $error("second segment on single-segment cell");
  assert property (@(posedge clk_i) disable iff (!rst_ni) k_q |=> !k_q)
    else $error("more than two segments");
endmodule

>>> rtl/core/marching_squares_cell.sv
// Marching squares cell, top level: case index, a divider per cell edge, segment sequencer.
// The first segment strobe follows acceptance through stage 1, stage 2, the dividers and the emit queue.
// Throughput: one cell per cycle while busy is low; the second segment of a cell follows in the next cycle.
// busy rises when the internal cell queue nears full; the receiver cannot stall.
// Reset clears all valid bits and the queue asynchronously. Depends on msq_pkg, msq_div, msq_emit.
`timescale 1ns / 1ps
module marching_squares_cell #(
  parameter int unsigned GRID_DIM    = msq_pkg::GridDimDefault,
  parameter int unsigned LEVEL_COUNT = msq_pkg::LevelCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [msq_pkg::CoordW-1:0]   cell_x_i,
  input  logic [msq_pkg::CoordW-1:0]   cell_y_i,
  input  logic signed [15:0]           height_ll_i,
  input  logic signed [15:0]           height_lr_i,
  input  logic signed [15:0]           height_ul_i,
  input  logic signed [15:0]           height_ur_i,
  input  logic [3:0]                   corner_valid_i,
  input  logic signed [15:0]           contour_level_i,
  input  logic [msq_pkg::TagW-1:0]     level_tag_i,
  output logic                         strobe,
  output logic [msq_pkg::TagW-1:0]     level_tag_out_o,
  output logic [msq_pkg::PointW-1:0]   from_x_o,
  output logic [msq_pkg::PointW-1:0]   from_y_o,
  output logic [msq_pkg::PointW-1:0]   to_x_o,
  output logic [msq_pkg::PointW-1:0]   to_y_o,
  output logic [1:0]                   from_edge_o,
  output logic [1:0]                   to_edge_o,
  output logic                         last_o
);
  localparam int unsigned PW = msq_pkg::PointW;
  localparam int unsigned NW = 25;
  localparam int unsigned DW = 17;
  localparam int unsigned QW = msq_pkg::FracW;
  localparam int unsigned SW = $bits(msq_pkg::segs_t);
  localparam int unsigned CW = msq_pkg::CoordW;
  localparam int unsigned TW = msq_pkg::TagW + SW + 2*CW;

  logic acc;
  assign acc = start && !busy;

  // stage 1: case index and differences
  logic         v1_q;
  logic [3:0]   idx1_q;
  logic signed [18:0] sum1_q;
  logic signed [17:0] lev4_q;
  logic signed [16:0] n1_q [4], d1_q [4];
  logic [CW-1:0] x1_q, y1_q;
  logic [msq_pkg::TagW-1:0] t1_q;
  logic ok;
  assign ok = (corner_valid_i == 4'hF) && (32'(cell_x_i) < GRID_DIM - 1)
           && (32'(cell_y_i) < GRID_DIM - 1) && (32'(level_tag_i) < LEVEL_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= acc && ok;
  end

  // edges: 0 ll->lr, 1 lr->ur, 2 ul->ur, 3 ll->ul
  always_ff @(posedge clk_i) begin
    idx1_q <= {height_ul_i >= contour_level_i, height_ur_i >= contour_level_i,
               height_lr_i >= contour_level_i, height_ll_i >= contour_level_i};
    sum1_q <= 19'(height_ll_i) + 19'(height_lr_i) + 19'(height_ul_i) + 19'(height_ur_i);
    lev4_q <= 18'(contour_level_i) <<< 2;
    n1_q[0] <= 17'(contour_level_i) - 17'(height_ll_i);
    d1_q[0] <= 17'(height_lr_i) - 17'(height_ll_i);
    n1_q[1] <= 17'(contour_level_i) - 17'(height_lr_i);
    d1_q[1] <= 17'(height_ur_i) - 17'(height_lr_i);
    n1_q[2] <= 17'(contour_level_i) - 17'(height_ul_i);
    d1_q[2] <= 17'(height_ur_i) - 17'(height_ul_i);
    n1_q[3] <= 17'(contour_level_i) - 17'(height_ll_i);
    d1_q[3] <= 17'(height_ul_i) - 17'(height_ll_i);
    x1_q <= cell_x_i; y1_q <= cell_y_i; t1_q <= level_tag_i;
  end

  // stage 2: sign-normalise each edge, clamp, table lookup
  logic v2_q;
  msq_pkg::segs_t segs2_q;
  logic [NW-1:0] n2_q [4];
  logic [DW-1:0] d2_q [4];
  logic [1:0]    cl2_q [4];
  logic [CW-1:0] x2_q, y2_q;
  logic [msq_pkg::TagW-1:0] t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  for (genvar e = 0; e < 4; e++) begin : g_norm
    logic neg;
    logic [16:0] an, ad;
    assign neg = d1_q[e][16];
    assign an = neg ? 17'(-n1_q[e]) : n1_q[e];
    assign ad = neg ? 17'(-d1_q[e]) : d1_q[e];
    always_ff @(posedge clk_i) begin
      n2_q[e] <= {an[15:0], 8'd0, 1'b0} >> 1;
      d2_q[e] <= ad;
      // 0: zero, 1: full, 2: divide
      if (d1_q[e] == '0 || an[16] || an == '0) cl2_q[e] <= 2'd0;
      else if (an >= ad) cl2_q[e] <= 2'd1;
      else cl2_q[e] <= 2'd2;
    end
  end

  always_ff @(posedge clk_i) begin
    segs2_q <= msq_pkg::case_segs(idx1_q, sum1_q < 19'(lev4_q));
    x2_q <= x1_q; y2_q <= y1_q; t2_q <= t1_q;
  end

  // dividers
  logic [3:0]    dv;
  logic [QW-1:0] q [4];
  logic [TW+7:0] dt [4];
  for (genvar e = 0; e < 4; e++) begin : g_div
    msq_div #(.NumW(NW), .DenW(DW), .QW(QW), .TagW(TW+8)) u_div (
      .clk_i, .rst_ni, .valid_i(v2_q), .num_i(n2_q[e]), .den_i(d2_q[e]),
      .tag_i({t2_q, segs2_q, x2_q, y2_q, cl2_q[0], cl2_q[1], cl2_q[2], cl2_q[3]}),
      .valid_o(dv[e]), .quo_o(q[e]), .tag_o(dt[e]));
  end

  // stage: assemble points
  logic [8:0] fr [4];
  logic [msq_pkg::TagW-1:0] tg;
  msq_pkg::segs_t sg;
  logic [CW-1:0] cx, cy;
  logic [1:0] cl [4];
  assign {tg, sg, cx, cy, cl[0], cl[1], cl[2], cl[3]} = dt[0];
  for (genvar e = 0; e < 4; e++) begin : g_fr
    assign fr[e] = (cl[e] == 2'd0) ? 9'd0 : (cl[e] == 2'd1) ? 9'd256 : q[e];
  end
  logic [PW-1:0] bx, by, bx1, by1;
  assign bx  = PW'(cx) << 8;
  assign by  = PW'(cy) << 8;
  assign bx1 = bx + PW'(256);
  assign by1 = by + PW'(256);
  logic [8*PW-1:0] pts;
  assign pts = {bx, by + PW'(fr[3]),
                bx + PW'(fr[2]), by1,
                bx1, by + PW'(fr[1]),
                bx + PW'(fr[0]), by};

  logic full;
  msq_emit #(.Depth(32)) u_emit (
    .clk_i, .rst_ni, .valid_i(dv[0]), .tag_i(tg), .segs_i(sg), .pts_i(pts),
    .full_o(full), .seg_valid_o(strobe), .tag_o(level_tag_out_o),
    .from_x_o, .from_y_o, .to_x_o, .to_y_o, .from_edge_o, .to_edge_o, .last_o);
  assign busy = full;

  assert property (@(posedge clk_i) disable iff (!rst_ni) dv[0] |-> dv[3])
    else $error("divider lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v2_q |-> $past(v1_q))
    else $error("valid lost between stages");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (acc && !ok) |=> !v1_q)
    else $error("rejected cell entered pipeline");
endmodule

>>> tb/tb.sv
// Self-checking testbench for marching_squares_cell: queue-fed driver, strobe monitor,
// and an in-bench segment predictor. Depends on msq_pkg and the cell RTL.
`timescale 1ns / 1ps
module tb;
  typedef msq_pkg::edge_e edge_e;
  localparam edge_e EdgeBottom = msq_pkg::EdgeBottom;
  localparam edge_e EdgeRight  = msq_pkg::EdgeRight;
  localparam edge_e EdgeTop    = msq_pkg::EdgeTop;
  localparam edge_e EdgeLeft   = msq_pkg::EdgeLeft;

  typedef struct {
    logic [9:0]         cx;
    logic [9:0]         cy;
    logic signed [15:0] ll, lr, ul, ur;
    logic [3:0]         valid;
    logic signed [15:0] lev;
    logic [5:0]         tag;
    bit                 drain;
  } cell_t;

  typedef struct {
    logic [5:0]  tag;
    logic [18:0] fx, fy, tx, ty;
    edge_e       fe, te;
    logic        last;
  } seg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, strobe;
  logic [9:0] cell_x_i = '0, cell_y_i = '0;
  logic signed [15:0] height_ll_i = '0, height_lr_i = '0, height_ul_i = '0, height_ur_i = '0;
  logic [3:0] corner_valid_i = '0;
  logic signed [15:0] contour_level_i = '0;
  logic [5:0] level_tag_i = '0;
  logic [5:0] level_tag_out_o;
  logic [18:0] from_x_o, from_y_o, to_x_o, to_y_o;
  logic [1:0] from_edge_o, to_edge_o;
  logic last_o;

  cell_t pending_cells[$];
  seg_t  due_segs[$];
  bit    failed = 1'b0;
  int    gap_left = 0;
  int    beats = 0;
  bit    calm = 1'b0;

  always #10 clk_i = ~clk_i;

  marching_squares_cell i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .cell_x_i, .cell_y_i, .height_ll_i, .height_lr_i, .height_ul_i, .height_ur_i,
    .corner_valid_i, .contour_level_i, .level_tag_i,
    .strobe, .level_tag_out_o, .from_x_o, .from_y_o, .to_x_o, .to_y_o,
    .from_edge_o, .to_edge_o, .last_o
  );

  function automatic longint frac_on(longint lev, longint a, longint b);
    longint q;
    if (b == a) return 0;
    q = ((lev - a) * 256) / (b - a);
    if (q < 0) q = 0;
    if (q > 256) q = 256;
    return q;
  endfunction

  function automatic void crossing(edge_e e, cell_t c, output logic [18:0] px,
                                   output logic [18:0] py);
    longint bx, by, x, y;
    bx = longint'(c.cx) * 256;
    by = longint'(c.cy) * 256;
    case (e)
      EdgeBottom: begin x = bx + frac_on(c.lev, c.ll, c.lr); y = by; end
      EdgeRight:  begin x = bx + 256; y = by + frac_on(c.lev, c.lr, c.ur); end
      EdgeTop:    begin x = bx + frac_on(c.lev, c.ul, c.ur); y = by + 256; end
      default:    begin x = bx; y = by + frac_on(c.lev, c.ll, c.ul); end
    endcase
    px = x[18:0];
    py = y[18:0];
  endfunction

  task automatic predict_segments(cell_t c);
    logic [3:0] idx;
    edge_e e[4];
    int n;
    longint total;
    seg_t s;
    if (c.valid != 4'hF || c.cx >= 10'd1023 || c.cy >= 10'd1023) return;
    idx = {c.ul >= c.lev, c.ur >= c.lev, c.lr >= c.lev, c.ll >= c.lev};
    total = longint'(c.ll) + c.lr + c.ul + c.ur;
    n = 1;
    case (idx)
      4'd1:  e = '{EdgeBottom, EdgeLeft, EdgeBottom, EdgeBottom};
      4'd2:  e = '{EdgeRight, EdgeBottom, EdgeBottom, EdgeBottom};
      4'd3:  e = '{EdgeRight, EdgeLeft, EdgeBottom, EdgeBottom};
      4'd4:  e = '{EdgeTop, EdgeRight, EdgeBottom, EdgeBottom};
      4'd5:  begin
        n = 2;
        if (total < 4 * longint'(c.lev)) e = '{EdgeBottom, EdgeRight, EdgeTop, EdgeLeft};
        else e = '{EdgeBottom, EdgeLeft, EdgeTop, EdgeRight};
      end
      4'd6:  e = '{EdgeTop, EdgeBottom, EdgeBottom, EdgeBottom};
      4'd7:  e = '{EdgeTop, EdgeLeft, EdgeBottom, EdgeBottom};
      4'd8:  e = '{EdgeLeft, EdgeTop, EdgeBottom, EdgeBottom};
      4'd9:  e = '{EdgeBottom, EdgeTop, EdgeBottom, EdgeBottom};
      4'd10: begin
        n = 2;
        if (total < 4 * longint'(c.lev)) e = '{EdgeLeft, EdgeBottom, EdgeRight, EdgeTop};
        else e = '{EdgeRight, EdgeBottom, EdgeLeft, EdgeTop};
      end
      4'd11: e = '{EdgeRight, EdgeTop, EdgeBottom, EdgeBottom};
      4'd12: e = '{EdgeLeft, EdgeRight, EdgeBottom, EdgeBottom};
      4'd13: e = '{EdgeBottom, EdgeRight, EdgeBottom, EdgeBottom};
      4'd14: e = '{EdgeLeft, EdgeBottom, EdgeBottom, EdgeBottom};
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      s.tag = c.tag;
      s.fe = e[2*k];
      s.te = e[2*k+1];
      crossing(s.fe, c, s.fx, s.fy);
      crossing(s.te, c, s.tx, s.ty);
      s.last = (k == n - 1);
      due_segs.insert(due_segs.size(), s);
    end
  endtask

  function automatic logic signed [15:0] corner_at(bit hi, int lev, int span);
    if (hi) return 16'($urandom_range(lev + 65536,
                                      ((lev + span > 32767) ? 32767 : lev + span) + 65536)
                       - 65536);
    return 16'($urandom_range((lev - span < -32768) ? -32768 + 65536 : lev - span + 65536,
                              lev - 1 + 65536) - 65536);
  endfunction

  function automatic cell_t shaped_cell(logic [3:0] idx, int lev, int span);
    cell_t c;
    c.cx = 10'($urandom_range(0, 1022));
    c.cy = 10'($urandom_range(0, 1022));
    c.lev = 16'(lev);
    c.ll = corner_at(idx[0], lev, span);
    c.lr = corner_at(idx[1], lev, span);
    c.ur = corner_at(idx[2], lev, span);
    c.ul = corner_at(idx[3], lev, span);
    c.valid = 4'hF;
    c.tag = 6'($urandom_range(0, 63));
    c.drain = 1'b0;
    return c;
  endfunction

  function automatic cell_t fixed_cell(int x, int y, int ll, int lr, int ul, int ur,
                                       int v, int lev, int tag);
    cell_t c;
    c = '{10'(x), 10'(y), 16'(ll), 16'(lr), 16'(ul), 16'(ur), 4'(v), 16'(lev), 6'(tag), 1'b0};
    return c;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    cell_t c;
    bit taken;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        predict_segments('{cell_x_i, cell_y_i, height_ll_i, height_lr_i, height_ul_i,
                           height_ur_i, corner_valid_i, contour_level_i, level_tag_i, 1'b0});
        beats++;
        if (beats % 120 == 0) calm = ~calm;
        gap_left = calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 13));
      end
      if (start && !taken) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cells.size() > 0 &&
                   !(pending_cells[0].drain && due_segs.size() > 0)) begin
        c = pending_cells[0];
        pending_cells.delete(0);
        cell_x_i <= c.cx;
        cell_y_i <= c.cy;
        height_ll_i <= c.ll;
        height_lr_i <= c.lr;
        height_ul_i <= c.ul;
        height_ur_i <= c.ur;
        corner_valid_i <= c.valid;
        contour_level_i <= c.lev;
        level_tag_i <= c.tag;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    seg_t s;
    if (rst_ni && strobe) begin
      if (due_segs.size() == 0) begin
        $error("segment beat with none expected");
        failed = 1'b1;
      end else begin
        s = due_segs[0];
        due_segs.delete(0);
        if (level_tag_out_o !== s.tag) begin
          $error("level_tag_out exp %0d got %0d", s.tag, level_tag_out_o); failed = 1'b1;
        end
        if (from_x_o !== s.fx) begin
          $error("from_x exp %0d got %0d", s.fx, from_x_o); failed = 1'b1;
        end
        if (from_y_o !== s.fy) begin
          $error("from_y exp %0d got %0d", s.fy, from_y_o); failed = 1'b1;
        end
        if (to_x_o !== s.tx) begin
          $error("to_x exp %0d got %0d", s.tx, to_x_o); failed = 1'b1;
        end
        if (to_y_o !== s.ty) begin
          $error("to_y exp %0d got %0d", s.ty, to_y_o); failed = 1'b1;
        end
        if (from_edge_o !== s.fe) begin
          $error("from_edge exp %0d got %0d", s.fe, from_edge_o); failed = 1'b1;
        end
        if (to_edge_o !== s.te) begin
          $error("to_edge exp %0d got %0d", s.te, to_edge_o); failed = 1'b1;
        end
        if (last_o !== s.last) begin
          $error("last exp %0d got %0d", s.last, last_o); failed = 1'b1;
        end
      end
    end
  end

  initial begin
    cell_t c;
    int lev, span, r;
    for (int i = 0; i < 16; i++)
      pending_cells.insert(pending_cells.size(), shaped_cell(4'(i), 0, 300));
    pending_cells.insert(pending_cells.size(), fixed_cell(3, 4, 100, -300, -300, 100, 15, 0, 1));
    pending_cells.insert(pending_cells.size(), fixed_cell(3, 4, 400, -10, -10, 400, 15, 0, 2));
    pending_cells.insert(pending_cells.size(), fixed_cell(5, 6, -300, 100, 100, -300, 15, 0, 3));
    pending_cells.insert(pending_cells.size(), fixed_cell(5, 6, -10, 400, 400, -10, 15, 0, 4));
    pending_cells.insert(pending_cells.size(),
                         fixed_cell(1022, 1022, -32768, 32767, 32767, -32768, 15, 0, 63));
    pending_cells.insert(pending_cells.size(), fixed_cell(0, 0, 5, 5, -7, 9, 15, 5, 0));
    pending_cells.insert(pending_cells.size(), fixed_cell(1023, 7, -5, 5, 5, 5, 15, 0, 9));
    pending_cells.insert(pending_cells.size(), fixed_cell(7, 1023, -5, 5, 5, 5, 15, 0, 9));
    pending_cells.insert(pending_cells.size(), fixed_cell(7, 7, -5, 5, 5, 5, 7, 0, 9));
    pending_cells.insert(pending_cells.size(),
                         fixed_cell(7, 7, -32768, 32767, -32768, 32767, 15, 32767, 10));
    for (int i = 0; i < 1650; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        c = fixed_cell($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 15), $urandom, $urandom_range(0, 63));
      end else begin
        lev = $urandom_range(0, 65534) - 32767;
        span = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 600);
        c = shaped_cell(4'($urandom_range(0, 15)), lev, span);
      end
      c.drain = (i % 400 == 200);
      pending_cells.insert(pending_cells.size(), c);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_cells.size() > 0 || start || due_segs.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (!failed && due_segs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/msq_pkg.sv
rtl/core/msq_div.sv
rtl/core/msq_emit.sv
rtl/core/marching_squares_cell.sv
tb/tb.sv
